>>> rtl/core/swvf_pkg.sv
// ----------------------------------------------------------------------------
// swvf_pkg
// Shared field widths, operation and status codes, and the command and
// status bundles passed between the stack controller and its datapath.
// ----------------------------------------------------------------------------
package swvf_pkg;

  // Item field widths
  localparam int KIND_W   = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FILTER = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic take;      // item accepted this cycle
    logic filt_run;  // filter walk in progress
    logic load_out;  // move result into the output register
  } swvf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic filt_done; // walk finished, compaction complete
  } swvf_sts_t;

endpackage

>>> rtl/core/swvf_ctrl.sv
// ----------------------------------------------------------------------------
// swvf_ctrl
// Sequencer for the stack: takes one item at a time, runs the filter walk
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module swvf_ctrl
  import swvf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] in_kind,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  swvf_sts_t         sts,
  output swvf_cmd_t         cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_FILT   = 2'd1;
  localparam logic [1:0] S_RESULT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = (in_kind == KIND_FILTER) ? S_FILT : S_RESULT;
        end
      end
      S_FILT: begin
        cmd.filt_run = 1'b1;
        if (sts.filt_done) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register occupancy
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // A taken item always moves the sequencer out of idle
  a_take_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("swvf_ctrl: accepted item did not start work");

  // A result load always marks the output register full
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("swvf_ctrl: loaded result not presented");

endmodule

>>> rtl/core/swvf_dp.sv
// ----------------------------------------------------------------------------
// swvf_dp
// Stack datapath: entry memory, fill count, filter compaction pointers and
// the output register.
// ----------------------------------------------------------------------------
module swvf_dp
  import swvf_pkg::*;
#(
  parameter int DEPTH = 64
)
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [KIND_W-1:0]          in_kind,
  input  logic signed [DATA_W-1:0]   in_value,
  input  swvf_cmd_t                  cmd,
  output swvf_sts_t                  sts,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [DATA_W-1:0]   out_popped_value,
  output logic [COUNT_W-1:0]         out_fill_count,
  output logic [COUNT_W-1:0]         out_removed_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // Entry memory
  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_r;

  logic                     wr_en, rd_en;
  logic [AW-1:0]            wr_addr, rd_addr;
  logic signed [DATA_W-1:0] wr_data;

  // Control and working registers
  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]            kept_r, kept_nxt;
  logic                     rd_vld_r, rd_vld_nxt;
  logic [CW-1:0]            removed_r, removed_nxt;
  logic [KIND_W-1:0]        kind_r, kind_nxt;
  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic [STATUS_W-1:0]      status_r, status_nxt;

  logic [CW-1:0] cnt_dec;
  logic          is_full, is_empty;

  assign cnt_dec  = count_r - CW'(1);
  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);

  // Walk is done once every entry is read and the last compare is made
  assign sts.filt_done = !rd_vld_r && (rd_idx_r == count_r);

  // Operation datapath
  always_comb begin
    count_nxt   = count_r;
    rd_idx_nxt  = rd_idx_r;
    kept_nxt    = kept_r;
    rd_vld_nxt  = rd_vld_r;
    removed_nxt = removed_r;
    kind_nxt    = kind_r;
    value_nxt   = value_r;
    status_nxt  = status_r;
    wr_en       = 1'b0;
    wr_addr     = count_r[AW-1:0];
    wr_data     = in_value;
    rd_en       = 1'b0;
    rd_addr     = rd_idx_r[AW-1:0];

    if (cmd.take) begin
      kind_nxt   = in_kind;
      value_nxt  = in_value;
      status_nxt = ST_OK;
      rd_idx_nxt = '0;
      kept_nxt   = '0;
      rd_vld_nxt = 1'b0;
      case (in_kind)
        KIND_PUSH: begin
          if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        KIND_POP: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = cnt_dec[AW-1:0];
            count_nxt = cnt_dec;
          end
        end
        default: ;
      endcase
    end else if (cmd.filt_run) begin
      // issue the next read
      if (rd_idx_r != count_r) begin
        rd_en      = 1'b1;
        rd_idx_nxt = rd_idx_r + CW'(1);
        rd_vld_nxt = 1'b1;
      end else begin
        rd_vld_nxt = 1'b0;
      end
      // keep a non-matching entry at the compaction pointer
      if (rd_vld_r && (rdata_r != value_r)) begin
        wr_en    = 1'b1;
        wr_addr  = kept_r[AW-1:0];
        wr_data  = rdata_r;
        kept_nxt = kept_r + CW'(1);
      end
      if (sts.filt_done) begin
        count_nxt   = kept_r;
        removed_nxt = count_r - kept_r;
      end
    end
  end

  // Memory write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Memory read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_idx_r <= '0;
      kept_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      rd_idx_r <= rd_idx_nxt;
      kept_r   <= kept_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  // Item payload
  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    value_r   <= value_nxt;
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status        <= status_r;
      out_popped_value  <= (kind_r == KIND_POP && status_r == ST_OK) ? rdata_r : '0;
      out_fill_count    <= COUNT_W'(count_r);
      out_removed_count <= (kind_r == KIND_FILTER) ? COUNT_W'(removed_r) : '0;
    end
  end

  // Fill count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("swvf_dp: fill count beyond capacity");

  // Compaction pointer never overtakes the read pointer
  a_kept_behind: assert property (@(posedge clk) disable iff (!rst_n)
    kept_r <= rd_idx_r)
    else $error("swvf_dp: write pointer ahead of read pointer");

endmodule

>>> rtl/core/stack_with_value_filter.sv
// ----------------------------------------------------------------------------
// stack_with_value_filter
// Bounded LIFO stack of signed words with push, pop and value filter.
// ----------------------------------------------------------------------------
// One item is worked on at a time; every item gives one result. Push, pop
// and the unused kind code go from acceptance to the result state and then,
// once the output register is free, into it; the next item is taken only
// after that load. Filter walks the stored entries through the single-read,
// single-write entry memory, one entry per cycle with a registered read. A
// new item is taken while the previous result still waits in the output
// register.
// ----------------------------------------------------------------------------
module stack_with_value_filter
  import swvf_pkg::*;
#(
  parameter int DEPTH = 64
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic signed [DATA_W-1:0] out_popped_value,
  output logic [COUNT_W-1:0]       out_fill_count,
  output logic [COUNT_W-1:0]       out_removed_count
);

  swvf_cmd_t cmd;
  swvf_sts_t sts;

  // Sequencer
  swvf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage and arithmetic
  swvf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_kind           (in_kind),
    .in_value          (in_value),
    .cmd               (cmd),
    .sts               (sts),
    .out_status        (out_status),
    .out_popped_value  (out_popped_value),
    .out_fill_count    (out_fill_count),
    .out_removed_count (out_removed_count)
  );

endmodule

>>> sim/tb_stack_with_value_filter.sv
// ----------------------------------------------------------------------------
// tb_stack_with_value_filter
// Self-checking bench for the bounded LIFO stack with value filter. A short
// table of directed items (empty cases, extremes, every kind code)
// is followed by random push, pop, drain, fill and filter sequences. A shadow
// stack predicts each result; results are checked field by field in order.
// Both sides idle at random, and the receiver once holds off for a long
// stretch so that the block backs up onto its input.
// ----------------------------------------------------------------------------
module tb_stack_with_value_filter;
  import swvf_pkg::*;

  localparam int DEPTH        = 64;
  localparam int RAND_ITEMS   = 1330;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = DEPTH + 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT_ITEM = 700;
  localparam int CALM_FIRST   = 300;
  localparam int CALM_LAST    = 500;
  localparam int IDLE_PCT     = 28;

  // Unused kind code: acts as a no-op
  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] popped;
    logic [COUNT_W-1:0]       fill;
    logic [COUNT_W-1:0]       removed;
  } stack_result_t;

  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
    bit                       typed;
    stack_result_t            want;
  } stim_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [KIND_W-1:0]        in_kind;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_stall;
  logic [STATUS_W-1:0]      out_status;
  logic signed [DATA_W-1:0] out_popped_value;
  logic [COUNT_W-1:0]       out_fill_count;
  logic [COUNT_W-1:0]       out_removed_count;

  // Shadow copy of the stack
  logic signed [DATA_W-1:0] shadow_stack [DEPTH];
  int unsigned              shadow_fill;

  stack_result_t pending_results [$];
  stim_row_t     stim_table [$];

  int errors;
  int items_sent;
  int results_seen;
  int full_refusals;
  int empty_pops;
  int filters_run;
  int entries_removed;
  int cycle_count;
  bit hold_done;

  stack_with_value_filter #(.DEPTH(DEPTH)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_fill_count   (out_fill_count),
    .out_removed_count(out_removed_count)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Work out the result of one operation and update the shadow stack
  function automatic stack_result_t apply_stack_op(input logic [KIND_W-1:0] kind,
                                                   input logic signed [DATA_W-1:0] value);
    stack_result_t res;
    int unsigned   kept;
    res = '0;
    res.status = ST_OK;
    case (kind)
      KIND_PUSH: begin
        if (shadow_fill >= DEPTH) begin
          res.status = ST_FULL;
          full_refusals++;
        end else begin
          shadow_stack[shadow_fill] = value;
          shadow_fill++;
        end
      end
      KIND_POP: begin
        if (shadow_fill == 0) begin
          res.status = ST_EMPTY;
          empty_pops++;
        end else begin
          shadow_fill--;
          res.popped = shadow_stack[shadow_fill];
        end
      end
      KIND_FILTER: begin
        // compact survivors downwards, keeping their order
        kept = 0;
        for (int unsigned i = 0; i < shadow_fill; i++) begin
          if (shadow_stack[i] != value) begin
            shadow_stack[kept] = shadow_stack[i];
            kept++;
          end
        end
        res.removed = COUNT_W'(shadow_fill - kept);
        entries_removed += shadow_fill - kept;
        filters_run++;
        shadow_fill = kept;
      end
      default: ;
    endcase
    res.fill = COUNT_W'(shadow_fill);
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch on result %0d, %0s: expected %0h, got %0h",
             results_seen, field, want, got);
    errors++;
  endtask

  // Random idle decision; no idling during the calm window
  function automatic bit idle_now();
    if (items_sent >= CALM_FIRST && items_sent < CALM_LAST) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  // Offer one item, wait for acceptance, then record what it should give
  task automatic send_item(input logic [KIND_W-1:0] kind,
                           input logic signed [DATA_W-1:0] value,
                           input bit typed = 1'b0,
                           input stack_result_t want = '0);
    stack_result_t res;
    while (idle_now()) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    res = apply_stack_op(kind, value);
    pending_results.push_back(typed ? want : res);
    items_sent++;
  endtask

  // Words biased towards a small set so that filters find matches
  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'sd0;
      1: return -32'sd1;
      2: return 32'sd7;
      3: return WORD_MAX;
      4: return WORD_MIN;
      5: return DATA_W'($urandom_range(0, 3));
      default: return $urandom();
    endcase
  endfunction

  // Filter value: mostly one that is held, so that something is removed
  function automatic logic signed [DATA_W-1:0] pick_filter_value();
    if (shadow_fill != 0 && $urandom_range(0, 99) < 65)
      return shadow_stack[$urandom_range(0, shadow_fill - 1)];
    return pick_word();
  endfunction

  task automatic run_random_items(input int count);
    int target;
    int burst;
    target = items_sent + count;
    while (items_sent < target) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: begin
          burst = $urandom_range(1, 12);
          repeat (burst) send_item(KIND_PUSH, pick_word());
        end
        6, 7, 8: begin
          burst = $urandom_range(1, 10);
          repeat (burst) send_item(KIND_POP, $urandom());
        end
        9, 10, 11, 12: send_item(KIND_FILTER, pick_filter_value());
        13: send_item(KIND_NOP, $urandom());
        14, 15: begin
          // fill to the top, then knock on a full stack
          while (shadow_fill < DEPTH) send_item(KIND_PUSH, pick_word());
          burst = $urandom_range(1, 3);
          repeat (burst) send_item(KIND_PUSH, $urandom());
          if ($urandom_range(0, 1)) send_item(KIND_FILTER, pick_filter_value());
        end
        16, 17: begin
          // drain to empty, then pop some more
          while (shadow_fill > 0) send_item(KIND_POP, $urandom());
          burst = $urandom_range(1, 3);
          repeat (burst) send_item(KIND_POP, $urandom());
        end
        default: begin
          // noise: any kind code, any word
          burst = $urandom_range(1, 8);
          repeat (burst) send_item(KIND_W'($urandom_range(0, 3)), $urandom());
        end
      endcase
    end
  endtask

  function automatic stim_row_t mk_row(input logic [KIND_W-1:0] kind,
                                       input logic signed [DATA_W-1:0] value,
                                       input bit typed = 1'b0,
                                       input logic [STATUS_W-1:0] status = ST_OK,
                                       input logic signed [DATA_W-1:0] popped = '0,
                                       input int fill = 0, input int removed = 0);
    stim_row_t row;
    row.kind         = kind;
    row.value        = value;
    row.typed        = typed;
    row.want.status  = status;
    row.want.popped  = popped;
    row.want.fill    = COUNT_W'(fill);
    row.want.removed = COUNT_W'(removed);
    return row;
  endfunction

  // Receiver: random stalls, one long hold-off, none in the calm window
  int hold_left;
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_now();
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    stack_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result %0d: status %0d popped %0h fill %0d removed %0d",
                 results_seen, out_status, out_popped_value, out_fill_count,
                 out_removed_count);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(out_status));
        if (out_popped_value !== want.popped)
          report_mismatch("popped_value", want.popped, out_popped_value);
        if (out_fill_count !== want.fill)
          report_mismatch("fill_count", 32'(want.fill), 32'(out_fill_count));
        if (out_removed_count !== want.removed)
          report_mismatch("removed_count", 32'(want.removed),
                          32'(out_removed_count));
      end
      results_seen++;
    end
  end

  // Stimulus and end of run
  initial begin
    errors          = 0;
    items_sent      = 0;
    results_seen    = 0;
    full_refusals   = 0;
    empty_pops      = 0;
    filters_run     = 0;
    entries_removed = 0;
    shadow_fill     = 0;
    in_valid        = 1'b0;
    in_kind         = KIND_PUSH;
    in_value        = '0;
    rst_n           = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed items: empty stack, extremes, no-op code, filter cases
    stim_table.push_back(mk_row(KIND_POP,    32'sd0,   1'b1, ST_EMPTY, 0, 0, 0));
    stim_table.push_back(mk_row(KIND_FILTER, 32'sd0,   1'b1, ST_OK, 0, 0, 0));
    stim_table.push_back(mk_row(KIND_NOP,    WORD_MAX, 1'b1, ST_OK, 0, 0, 0));
    stim_table.push_back(mk_row(KIND_PUSH,   WORD_MAX, 1'b1, ST_OK, 0, 1, 0));
    stim_table.push_back(mk_row(KIND_PUSH,   WORD_MIN, 1'b1, ST_OK, 0, 2, 0));
    stim_table.push_back(mk_row(KIND_POP,    -32'sd1,  1'b1, ST_OK, WORD_MIN, 1, 0));
    stim_table.push_back(mk_row(KIND_POP,    32'sd0,   1'b1, ST_OK, WORD_MAX, 0, 0));
    stim_table.push_back(mk_row(KIND_POP,    WORD_MIN, 1'b1, ST_EMPTY, 0, 0, 0));
    stim_table.push_back(mk_row(KIND_PUSH,   32'sd5));
    stim_table.push_back(mk_row(KIND_PUSH,   -32'sd1));
    stim_table.push_back(mk_row(KIND_PUSH,   32'sd5));
    stim_table.push_back(mk_row(KIND_PUSH,   32'sd0));
    stim_table.push_back(mk_row(KIND_PUSH,   32'sd5));
    stim_table.push_back(mk_row(KIND_FILTER, 32'sd7));
    stim_table.push_back(mk_row(KIND_NOP,    -32'sd1));
    stim_table.push_back(mk_row(KIND_FILTER, 32'sd5));
    stim_table.push_back(mk_row(KIND_POP,    32'sd0));
    stim_table.push_back(mk_row(KIND_POP,    32'sd0));
    stim_table.push_back(mk_row(KIND_PUSH,   WORD_MIN));
    stim_table.push_back(mk_row(KIND_PUSH,   WORD_MIN));
    stim_table.push_back(mk_row(KIND_FILTER, WORD_MIN, 1'b1, ST_OK, 0, 0, 2));
    stim_table.push_back(mk_row(KIND_POP,    WORD_MAX, 1'b1, ST_EMPTY, 0, 0, 0));
    foreach (stim_table[r])
      send_item(stim_table[r].kind, stim_table[r].value, stim_table[r].typed,
                stim_table[r].want);

    run_random_items(RAND_ITEMS);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d items, %0d results; %0d full refusals, %0d empty pops, %0d filters",
             items_sent, results_seen, full_refusals, empty_pops, filters_run);
    $display("filters removed %0d entries; %0d mismatches", entries_removed, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
